// ===== src/aopd_pkg.sv =====
// Shared types and constants for the octet-aligned AMR payload deframer.
// No dependencies; the parser, the result queue and the top level import it.
package aopd_pkg;

    // TOC store depth and the widths that follow from it
    localparam int MAX_TOCS = 64;
    localparam int TOC_AW   = $clog2(MAX_TOCS);
    localparam int CNT_W    = $clog2(MAX_TOCS + 1);

    // Result queue sizing: one input item pushes at most two results
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] PKT_LEN_RESET = 8'd65;
    localparam logic [3:0] FT_MAX        = 4'd9;

    // Speech frame size in bytes per frame type
    localparam logic [4:0] FRAME_BYTES [16] = '{
        5'd12, 5'd13, 5'd15, 5'd17, 5'd19, 5'd20, 5'd26, 5'd31,
        5'd5,  5'd6,  5'd5,  5'd5,  5'd0,  5'd0,  5'd0,  5'd0
    };

    typedef enum logic [2:0] {
        ST_OK  = 3'd0,
        ST_LEN = 3'd1,
        ST_TOC = 3'd2,
        ST_FT  = 3'd3,
        ST_OVR = 3'd4
    } t_status;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_out;
        logic [7:0] frame_header;
        logic [5:0] frame_index;
        logic       frame_start;
        logic       frame_end;
        t_status    status_code;
        logic [6:0] frames_found;
        logic       last_result;
    } t_result;

    // Results produced by one accepted item, in delivery order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== src/aopd_in_if.sv =====
// Byte input channel of the deframer: valid/ready handshake with payload.
// No dependencies.
interface aopd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       end_of_packet;

    modport source (output valid, output payload_byte, output end_of_packet, input ready);
    modport sink   (input valid, input payload_byte, input end_of_packet, output ready);
endinterface

// ===== src/aopd_out_if.sv =====
// Result output channel of the deframer: valid/ready handshake with payload.
// No dependencies.
interface aopd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_out;
    logic [7:0] frame_header;
    logic [5:0] frame_index;
    logic       frame_start;
    logic       frame_end;
    logic [2:0] status_code;
    logic [6:0] frames_found;
    logic       last_result;

    modport source (
        output valid, output kind, output data_out, output frame_header,
        output frame_index, output frame_start, output frame_end,
        output status_code, output frames_found, output last_result,
        input ready
    );
    modport sink (
        input valid, input kind, input data_out, input frame_header,
        input frame_index, input frame_start, input frame_end,
        input status_code, input frames_found, input last_result,
        output ready
    );
endinterface

// ===== src/aopd_parser.sv =====
// Per-byte payload parser: CMR skip, TOC store, frame splitting and status.
// Depends on aopd_pkg.
module aopd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_byte,
    input  logic           i_eop,
    input  logic [7:0]     i_packet_length,
    output aopd_pkg::t_push o_push
);
    import aopd_pkg::*;

    typedef enum logic [1:0] {
        PH_CMR,
        PH_TOC,
        PH_FRAMES,
        PH_IDLE
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [7:0]         r_byte_pos, n_byte_pos;
    logic [CNT_W-1:0]   r_toc_count, n_toc_count;
    logic [CNT_W-1:0]   r_cur_frame, n_cur_frame;
    logic [4:0]         r_left, n_left;
    t_status            r_err, n_err;
    logic [7:0]         r_first_toc, n_first_toc;
    logic [7:0]         r_cur_hdr, n_cur_hdr;
    logic [7:0]         r_next_hdr;
    logic [7:0]         r_toc_mem [MAX_TOCS];

    logic               mem_we;
    logic [TOC_AW-1:0]  pf_addr;
    logic [7:0]         hdr0;
    logic [CNT_W-1:0]   next_frame;
    logic [8:0]         total;
    t_result            data_res;
    t_result            status_res;

    // Prefetch the header of the frame after the current one
    assign pf_addr    = TOC_AW'(r_cur_frame + CNT_W'(1));
    assign next_frame = r_cur_frame + CNT_W'(1);
    assign hdr0       = (r_toc_count == '0) ? i_byte : r_first_toc;
    assign total      = {1'b0, r_byte_pos} + 9'd1;

    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_toc_count = r_toc_count;
        n_cur_frame = r_cur_frame;
        n_left      = r_left;
        n_err       = r_err;
        n_first_toc = r_first_toc;
        n_cur_hdr   = r_cur_hdr;
        mem_we      = 1'b0;
        data_res    = '0;
        status_res  = '0;
        o_push      = '0;

        if (i_fire) begin
            case (r_phase)
                PH_CMR: begin
                    n_phase = PH_TOC;
                end
                PH_TOC: begin
                    if (r_toc_count == CNT_W'(MAX_TOCS) || (i_byte[7] && i_eop)) begin
                        n_err   = ST_TOC;
                        n_phase = PH_IDLE;
                    end else begin
                        mem_we      = 1'b1;
                        n_toc_count = r_toc_count + CNT_W'(1);
                        if (r_toc_count == '0) begin
                            n_first_toc = i_byte;
                        end
                        // F bit clear: list done, open frame 0
                        if (!i_byte[7]) begin
                            n_cur_frame = '0;
                            if (hdr0[6:3] > FT_MAX) begin
                                n_err   = ST_FT;
                                n_phase = PH_IDLE;
                            end else begin
                                n_left    = FRAME_BYTES[hdr0[6:3]];
                                n_cur_hdr = hdr0;
                                n_phase   = PH_FRAMES;
                            end
                        end
                    end
                end
                PH_FRAMES: begin
                    data_res.kind         = 1'b0;
                    data_res.data_out     = i_byte;
                    data_res.frame_header = r_cur_hdr;
                    data_res.frame_index  = r_cur_frame[5:0];
                    data_res.frame_start  = (r_left == FRAME_BYTES[r_cur_hdr[6:3]]);
                    data_res.frame_end    = (r_left == 5'd1);
                    data_res.last_result  = !i_eop;
                    n_left = r_left - 5'd1;
                    if (r_left == 5'd1) begin
                        n_cur_frame = next_frame;
                        if (next_frame >= r_toc_count) begin
                            n_phase = PH_IDLE;
                        end else if (r_next_hdr[6:3] > FT_MAX) begin
                            n_err   = ST_FT;
                            n_phase = PH_IDLE;
                        end else begin
                            n_left    = FRAME_BYTES[r_next_hdr[6:3]];
                            n_cur_hdr = r_next_hdr;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (i_eop) begin
                status_res.kind         = 1'b1;
                status_res.frames_found = 7'(n_cur_frame);
                status_res.last_result  = 1'b1;
                if (total != {1'b0, i_packet_length}) begin
                    status_res.status_code = ST_LEN;
                end else if (n_err != ST_OK) begin
                    status_res.status_code = n_err;
                end else if (n_phase == PH_CMR || n_phase == PH_TOC) begin
                    status_res.status_code = ST_TOC;
                end else if (n_phase == PH_FRAMES) begin
                    status_res.status_code = ST_OVR;
                end else begin
                    status_res.status_code = ST_OK;
                end
                // Return all packet state to reset
                n_byte_pos  = '0;
                n_phase     = PH_CMR;
                n_toc_count = '0;
                n_cur_frame = '0;
                n_left      = '0;
                n_err       = ST_OK;
            end else if (r_byte_pos != 8'hff) begin
                n_byte_pos = r_byte_pos + 8'd1;
            end

            if (r_phase == PH_FRAMES) begin
                o_push.first  = data_res;
                o_push.second = status_res;
                o_push.count  = i_eop ? 2'd2 : 2'd1;
            end else if (i_eop) begin
                o_push.first = status_res;
                o_push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CMR;
            r_byte_pos  <= '0;
            r_toc_count <= '0;
            r_cur_frame <= '0;
            r_left      <= '0;
            r_err       <= ST_OK;
        end else begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_toc_count <= n_toc_count;
            r_cur_frame <= n_cur_frame;
            r_left      <= n_left;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_toc <= n_first_toc;
        r_cur_hdr   <= n_cur_hdr;
    end

    // TOC store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_toc_mem[r_toc_count[TOC_AW-1:0]] <= i_byte;
        end
        r_next_hdr <= r_toc_mem[pf_addr];
    end

`ifndef NO_ASSERTIONS
    a_toc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_toc_count <= CNT_W'(MAX_TOCS))
        else $error("TOC count beyond store depth");
    a_frame_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FRAMES |-> (r_left != '0 && r_cur_frame < r_toc_count))
        else $error("frame phase without a live frame");
    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eop) |=> (r_phase == PH_CMR && r_byte_pos == '0 && r_err == ST_OK))
        else $error("packet state not cleared after status");
`endif
endmodule

// ===== src/aopd_result_fifo.sv =====
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on aopd_pkg.
module aopd_result_fifo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  aopd_pkg::t_push          i_push,
    input  logic                     i_pop,
    output aopd_pkg::t_result        o_head,
    output logic [aopd_pkg::FIFO_CW-1:0] o_count
);
    import aopd_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr, n_wptr;
    logic [FIFO_AW-1:0]   r_rptr, n_rptr;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic [FIFO_AW-1:0]   wptr_1;

    assign wptr_1  = r_wptr + FIFO_AW'(1);
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

    always_comb begin
        n_wptr  = r_wptr + FIFO_AW'(i_push.count);
        n_rptr  = i_pop ? r_rptr + FIFO_AW'(1) : r_rptr;
        n_count = r_count + FIFO_CW'(i_push.count) - FIFO_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wptr_1] <= i_push.second;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != 2'd0 |-> r_count <= FIFO_CW'(FIFO_DEPTH - 2))
        else $error("push into a queue without room for two");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && i_push.count == 2'd0) |=> r_count == $past(r_count) - FIFO_CW'(1))
        else $error("queue count did not drop on pop");
`endif
endmodule

// ===== src/amr_octet_payload_deframer_unit.sv =====
// Top level of the octet-aligned AMR payload deframer.
// Depends on aopd_pkg, aopd_in_if, aopd_out_if, aopd_parser, aopd_result_fifo.
//
// Usage:
//   i_in   : one payload byte per item, CMR byte first; end_of_packet marks the
//            last byte of a payload.
//   o_out  : one result per item. kind 0 is a frame data byte with its TOC
//            byte, frame index and start/end marks; kind 1 is the packet status
//            (code and complete frame count) that follows the last byte.
//   i_cfg_we / i_cfg_wdata : write packet_length (exact payload size in bytes).
//            Write only while no packet is in flight.
// Results are registered into the result queue and offered on o_out in order.
// When the last byte is also a frame byte, its status follows its data result.
// Throughput: one byte per cycle while o_out takes results. The parser
// updates its counters and the TOC store per byte and pushes into a four-entry
// result queue; a last byte that carries frame data pushes two results.
// Stall: i_in.ready stays high while the queue has room for two results;
// when o_out is held off the queue fills and i_in.ready drops. Nothing is lost.
// Reset (synchronous, i_rst_n low): parser returns to expecting a CMR byte,
// queue empties, packet_length returns to 65. The TOC store is not cleared;
// only entries written in the current packet are ever read.
module amr_octet_payload_deframer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    aopd_in_if.sink           i_in,
    aopd_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata
);
    import aopd_pkg::*;

    logic [7:0]          r_packet_length;
    logic                in_fire;
    logic                out_pop;
    t_push               push;
    t_result             head;
    logic [FIFO_CW-1:0]  q_count;

    // Accept a byte only when the queue can hold both results it may cause
    assign i_in.ready = (q_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid = (q_count != '0);
    assign out_pop     = o_out.valid && o_out.ready;

    // Length register: written directly, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_length <= PKT_LEN_RESET;
        end else if (i_cfg_we) begin
            r_packet_length <= i_cfg_wdata;
        end
    end

    aopd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (in_fire),
        .i_byte          (i_in.payload_byte),
        .i_eop           (i_in.end_of_packet),
        .i_packet_length (r_packet_length),
        .o_push          (push)
    );

    aopd_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_pop),
        .o_head  (head),
        .o_count (q_count)
    );

    // Drive the output payload from the queue head
    assign o_out.kind         = head.kind;
    assign o_out.data_out     = head.data_out;
    assign o_out.frame_header = head.frame_header;
    assign o_out.frame_index  = head.frame_index;
    assign o_out.frame_start  = head.frame_start;
    assign o_out.frame_end    = head.frame_end;
    assign o_out.status_code  = head.status_code;
    assign o_out.frames_found = head.frames_found;
    assign o_out.last_result  = head.last_result;

endmodule
